/* rtl/bcc_pkg.sv */
`default_nettype none
package bcc_pkg;

	// Width of the press timer; the comparison width covers both it and the
	// 16-bit limit registers.
	localparam int TIMER_W = 16;
	localparam int CMP_W = (TIMER_W > 16) ? TIMER_W : 16;

	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W = 3;
	localparam int EVENT_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CLICK = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_CLICK = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_PAUSE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_EN = 3'd5;

	localparam logic [EVENT_W-1:0] EV_NONE = 3'd0;
	localparam logic [EVENT_W-1:0] EV_SHORT = 3'd1;
	localparam logic [EVENT_W-1:0] EV_SINGLE = 3'd2;
	localparam logic [EVENT_W-1:0] EV_LONG = 3'd3;
	localparam logic [EVENT_W-1:0] EV_DOUBLE = 3'd4;

	typedef struct packed {
		logic [15:0] debounce_ticks;
		logic [15:0] click_ticks;
		logic [15:0] long_click_ticks;
		logic [15:0] double_click_ticks;
		logic [15:0] pause_ticks;
		logic        double_click_enable;
	} cfg_t;

	typedef struct packed {
		logic [EVENT_W-1:0] click_event;
		logic               hold_feedback;
	} res_t;

endpackage
`default_nettype wire

/* rtl/bcc_cfg.sv */
`default_nettype none
module bcc_cfg (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           wr_en,
	input  wire logic [bcc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [bcc_pkg::CFG_DATA_W-1:0] wr_data,
	output bcc_pkg::cfg_t                       cfg
);

	bcc_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks <= 16'd4;
			cfg_q.click_ticks <= 16'd256;
			cfg_q.long_click_ticks <= 16'd1024;
			cfg_q.double_click_ticks <= 16'd64;
			cfg_q.pause_ticks <= 16'd128;
			cfg_q.double_click_enable <= 1'b1;
		end else if (wr_en) begin
			unique case (wr_index)
				bcc_pkg::REG_DEBOUNCE:     cfg_q.debounce_ticks <= wr_data;
				bcc_pkg::REG_CLICK:        cfg_q.click_ticks <= wr_data;
				bcc_pkg::REG_LONG_CLICK:   cfg_q.long_click_ticks <= wr_data;
				bcc_pkg::REG_DOUBLE_CLICK: cfg_q.double_click_ticks <= wr_data;
				bcc_pkg::REG_PAUSE:        cfg_q.pause_ticks <= wr_data;
				bcc_pkg::REG_DOUBLE_EN:    cfg_q.double_click_enable <= wr_data[0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* rtl/bcc_core.sv */
`default_nettype none
module bcc_core (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_stall,
	input  wire logic    button_level,
	input  wire bcc_pkg::cfg_t cfg,
	input  wire logic    res_load,
	output logic         res_valid,
	output bcc_pkg::res_t res
);

	typedef enum logic [2:0] {
		PH_IDLE    = 3'd0,
		PH_CONFIRM = 3'd1,
		PH_HOLD    = 3'd2,
		PH_WAIT2   = 3'd3,
		PH_PAUSE   = 3'd4
	} phase_t;

	phase_t                       phase_q, phase_d;
	logic [15:0]                  sample_timer_q, sample_timer_d;
	logic [bcc_pkg::TIMER_W-1:0]  press_elapsed_q, press_elapsed_d;
	logic                         second_press_q, second_press_d;
	logic                         valid_s1;
	logic                         button_s1;

	logic                         pressed;
	logic                         advance;
	logic                         accept;
	logic [15:0]                  st_inc;
	logic                         due;
	logic [bcc_pkg::TIMER_W-1:0]  pe_inc;
	logic [bcc_pkg::CMP_W-1:0]    pe_x;
	logic [bcc_pkg::CMP_W-1:0]    click_x;
	logic [bcc_pkg::CMP_W-1:0]    long_x;
	logic [bcc_pkg::CMP_W-1:0]    double_x;

	function automatic logic [bcc_pkg::EVENT_W-1:0] classify(
		input logic                       second,
		input logic [bcc_pkg::CMP_W-1:0]  elapsed,
		input logic [bcc_pkg::CMP_W-1:0]  click_lim,
		input logic [bcc_pkg::CMP_W-1:0]  long_lim,
		input logic [bcc_pkg::CMP_W-1:0]  double_lim
	);
		logic [bcc_pkg::EVENT_W-1:0] ev;
		priority if (second) begin
			ev = (elapsed < double_lim) ? bcc_pkg::EV_DOUBLE : bcc_pkg::EV_NONE;
		end else if (elapsed < click_lim) begin
			ev = bcc_pkg::EV_SHORT;
		end else if (elapsed < long_lim) begin
			ev = bcc_pkg::EV_SINGLE;
		end else begin
			ev = bcc_pkg::EV_LONG;
		end
		return ev;
	endfunction

	// The tick in the input register is processed when the result register
	// can take its result.
	assign advance = valid_s1 && res_load;
	assign in_stall = valid_s1 && !res_load;
	assign accept = in_valid && !in_stall;
	assign pressed = !button_s1;

	assign st_inc = (sample_timer_q != 16'hFFFF) ? sample_timer_q + 16'd1 : sample_timer_q;
	assign due = (st_inc >= cfg.debounce_ticks);
	assign pe_inc = (press_elapsed_q != {bcc_pkg::TIMER_W{1'b1}}) ?
		press_elapsed_q + {{(bcc_pkg::TIMER_W-1){1'b0}}, 1'b1} : press_elapsed_q;
	assign pe_x = bcc_pkg::CMP_W'(pe_inc);
	assign click_x = bcc_pkg::CMP_W'(cfg.click_ticks);
	assign long_x = bcc_pkg::CMP_W'(cfg.long_click_ticks);
	assign double_x = bcc_pkg::CMP_W'(cfg.double_click_ticks);

	always_comb begin
		phase_d = phase_q;
		sample_timer_d = sample_timer_q;
		press_elapsed_d = press_elapsed_q;
		second_press_d = second_press_q;
		res.click_event = bcc_pkg::EV_NONE;
		res.hold_feedback = 1'b0;
		unique case (phase_q)
			PH_CONFIRM: begin
				sample_timer_d = due ? 16'd0 : st_inc;
				if (due) begin
					if (pressed) begin
						phase_d = PH_HOLD;
						press_elapsed_d = '0;
						second_press_d = 1'b0;
					end else begin
						phase_d = PH_PAUSE;
					end
				end
			end
			PH_HOLD: begin
				press_elapsed_d = pe_inc;
				res.hold_feedback = (pe_x > click_x);
				sample_timer_d = due ? 16'd0 : st_inc;
				if (due && (pe_x >= long_x || !pressed)) begin
					if (cfg.double_click_enable && pe_x < double_x) begin
						phase_d = PH_WAIT2;
					end else begin
						res.click_event = classify(second_press_q, pe_x, click_x, long_x,
							double_x);
						phase_d = PH_PAUSE;
					end
				end
			end
			PH_WAIT2: begin
				press_elapsed_d = pe_inc;
				sample_timer_d = due ? 16'd0 : st_inc;
				if (due) begin
					second_press_d = pressed;
					if (pe_x >= double_x || pressed) begin
						res.click_event = classify(pressed, pe_x, click_x, long_x, double_x);
						phase_d = PH_PAUSE;
					end
				end
			end
			PH_PAUSE: begin
				sample_timer_d = st_inc;
				if (st_inc >= cfg.pause_ticks) begin
					phase_d = PH_IDLE;
					sample_timer_d = 16'd0;
				end
			end
			default: begin
				// Idle polling; unused phase codes fall back here as well.
				phase_d = PH_IDLE;
				sample_timer_d = due ? 16'd0 : st_inc;
				if (due && pressed) begin
					phase_d = PH_CONFIRM;
				end
			end
		endcase
	end

	assign res_valid = advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			sample_timer_q <= 16'd0;
			press_elapsed_q <= '0;
			second_press_q <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= (valid_s1 && !advance) || accept;
			if (advance) begin
				phase_q <= phase_d;
				sample_timer_q <= sample_timer_d;
				press_elapsed_q <= press_elapsed_d;
				second_press_q <= second_press_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			button_s1 <= button_level;
		end
	end

	a_event_enters_pause: assert property (@(posedge clk) disable iff (!arst_n)
		advance && res.click_event != bcc_pkg::EV_NONE |=> phase_q == PH_PAUSE)
		else $error("click event without entering pause");

	a_feedback_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res.hold_feedback |-> phase_q == PH_HOLD)
		else $error("hold feedback outside hold phase");

	a_state_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(phase_q) && $stable(sample_timer_q) && $stable(press_elapsed_q))
		else $error("state changed without a processed tick");

	a_stall_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1)
		else $error("input stalled with empty input register");

endmodule
`default_nettype wire

/* rtl/bcc_outreg.sv */
`default_nettype none
module bcc_outreg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         res_valid,
	input  wire bcc_pkg::res_t                res,
	output logic                              res_load,
	output logic                              out_valid,
	input  wire logic                         out_stall,
	output logic [bcc_pkg::EVENT_W-1:0]       click_event,
	output logic                              hold_feedback
);

	logic          out_valid_q;
	bcc_pkg::res_t res_q;

	// The register takes a new result when empty or when its contents leave
	// in the same cycle.
	assign res_load = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_load) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load && res_valid) begin
			res_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign click_event = res_q.click_event;
	assign hold_feedback = res_q.hold_feedback;

endmodule
`default_nettype wire

/* rtl/button_click_classifier_core.sv */
`default_nettype none
// Button click classifier. Each transfer on the input channel is one system
// tick carrying the raw active-low button level; each tick produces exactly
// one result transfer with a click event code (none, short, single, long,
// double) and a hold feedback flag.
// Input channel: in_valid / in_stall with button_level. Output channel:
// out_valid / out_stall with click_event and hold_feedback. A transfer
// happens on a rising edge where valid is high and stall is low.
// A tick goes into an input register, then through the classifier logic into
// the result register, from which its result transfer is made.
// Throughput: one tick per cycle unless the receiver stalls; the phase,
// sample and press counters are updated once per tick in a single step.
// While the receiver stalls, the result register holds and the input
// register can still take one more tick; after that in_stall is raised.
// The user writes registers via wr_en / wr_index / wr_data only while the
// block is idle; the block does not enforce this. Reset restores the default
// register values and returns to idle polling with all counters cleared.
module button_click_classifier_core (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output logic                                in_stall,
	input  wire logic                           button_level,
	output logic                                out_valid,
	input  wire logic                           out_stall,
	output logic [bcc_pkg::EVENT_W-1:0]         click_event,
	output logic                                hold_feedback,
	input  wire logic                           wr_en,
	input  wire logic [bcc_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire logic [bcc_pkg::CFG_DATA_W-1:0] wr_data
);

	bcc_pkg::cfg_t cfg;
	bcc_pkg::res_t res;
	logic          res_valid;
	logic          res_load;

	bcc_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	bcc_core u_core (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.button_level (button_level),
		.cfg          (cfg),
		.res_load     (res_load),
		.res_valid    (res_valid),
		.res          (res)
	);

	bcc_outreg u_outreg (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_valid     (res_valid),
		.res           (res),
		.res_load      (res_load),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.click_event   (click_event),
		.hold_feedback (hold_feedback)
	);

endmodule
`default_nettype wire
